// ===== rtl/core/stt_pkg.sv =====
package stt_pkg;

  typedef enum logic [4:0] {
    M_IDLE       = 5'd0,
    M_WORD       = 5'd1,
    M_INT        = 5'd2,
    M_INT_DOT    = 5'd3,
    M_FLOAT      = 5'd4,
    M_STR        = 5'd5,
    M_STR_ESC    = 5'd6,
    M_CHR        = 5'd7,
    M_CHR_ESC    = 5'd8,
    M_CHR_END    = 5'd9,
    M_OP         = 5'd10,
    M_LINE       = 5'd11,
    M_BLOCK      = 5'd12,
    M_BLOCK_STAR = 5'd13
  } lex_mode_e;

  localparam logic [1:0] CLS_TOKEN = 2'd0;
  localparam logic [1:0] CLS_TEXT  = 2'd1;
  localparam logic [1:0] CLS_ERROR = 2'd2;

  localparam logic [2:0] ERR_OPEN_STR   = 3'd0;
  localparam logic [2:0] ERR_OPEN_CHR   = 3'd1;
  localparam logic [2:0] ERR_BAD_ESC    = 3'd2;
  localparam logic [2:0] ERR_LONE_AMP   = 3'd3;
  localparam logic [2:0] ERR_LONE_PIPE  = 3'd4;
  localparam logic [2:0] ERR_BAD_CHAR   = 3'd5;

  localparam logic [5:0] K_INT    = 6'd0;
  localparam logic [5:0] K_FLOAT  = 6'd1;
  localparam logic [5:0] K_STR    = 6'd2;
  localparam logic [5:0] K_CHAR   = 6'd3;
  localparam logic [5:0] K_IDENT  = 6'd6;
  localparam logic [5:0] K_PLUS   = 6'd32;
  localparam logic [5:0] K_MINUS  = 6'd33;
  localparam logic [5:0] K_STAR   = 6'd34;
  localparam logic [5:0] K_SLASH  = 6'd35;
  localparam logic [5:0] K_ASSIGN = 6'd36;
  localparam logic [5:0] K_EQ     = 6'd37;
  localparam logic [5:0] K_NE     = 6'd38;
  localparam logic [5:0] K_NOT    = 6'd39;
  localparam logic [5:0] K_LT     = 6'd40;
  localparam logic [5:0] K_GT     = 6'd41;
  localparam logic [5:0] K_LE     = 6'd42;
  localparam logic [5:0] K_GE     = 6'd43;
  localparam logic [5:0] K_AND    = 6'd44;
  localparam logic [5:0] K_OR     = 6'd45;
  localparam logic [5:0] K_SEMI   = 6'd46;
  localparam logic [5:0] K_COLON  = 6'd47;
  localparam logic [5:0] K_COMMA  = 6'd48;
  localparam logic [5:0] K_DOT    = 6'd49;
  localparam logic [5:0] K_QUEST  = 6'd50;
  localparam logic [5:0] K_LPAR   = 6'd51;
  localparam logic [5:0] K_RPAR   = 6'd52;
  localparam logic [5:0] K_LBRACE = 6'd53;
  localparam logic [5:0] K_RBRACE = 6'd54;
  localparam logic [5:0] K_LBRACK = 6'd55;
  localparam logic [5:0] K_RBRACK = 6'd56;
  localparam logic [5:0] K_EOF    = 6'd57;

  localparam int MAXRES = 4;
  localparam int QDEPTH = 2;
  localparam int NKW    = 28;

  typedef struct packed {
    logic [1:0]  cls;
    logic [5:0]  kind;
    logic [7:0]  pay;
    logic [31:0] val;
    logic [2:0]  err;
    logic [15:0] line;
    logic [15:0] col;
  } res_t;

  typedef struct packed {
    res_t [MAXRES-1:0] r;
    logic [2:0]        n;
  } bundle_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] kind;
    logic       val;
  } kw_t;

  // Keyword text is right aligned: the last character sits in the low byte.
  localparam logic [55:0] KW_TXT [NKW] = '{
    "if", "else", "int", "char", "void", "null", "bool", "string", "def",
    "include", "extern", "while", "do", "for", "to", "return", "alloc",
    "free", "match", "some", "own", "ref", "const", "float", "double",
    "true", "false", "_"};
  localparam logic [2:0] KW_LEN [NKW] = '{
    3'd2, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd6, 3'd3, 3'd7, 3'd6, 3'd5,
    3'd2, 3'd3, 3'd2, 3'd6, 3'd5, 3'd4, 3'd5, 3'd4, 3'd3, 3'd3, 3'd5, 3'd5,
    3'd6, 3'd4, 3'd5, 3'd1};
  localparam logic [5:0] KW_KIND [NKW] = '{
    6'd7, 6'd8, 6'd9, 6'd10, 6'd11, 6'd5, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16,
    6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26,
    6'd27, 6'd28, 6'd29, 6'd30, 6'd4, 6'd4, 6'd31};

  function automatic kw_t kw_lookup(input logic [6:0][7:0] w, input logic [2:0] len);
    kw_t   res;
    logic  eq;
    int    l;
    res = '0;
    for (int k = 0; k < NKW; k++) begin
      l  = int'(KW_LEN[k]);
      eq = (KW_LEN[k] == len);
      for (int j = 0; j < 7; j++) begin
        if (j < l && w[j] != KW_TXT[k][(l-1-j)*8 +: 8]) eq = 1'b0;
      end
      if (eq && !res.hit) begin
        res.hit  = 1'b1;
        res.kind = KW_KIND[k];
        res.val  = (k == 25);
      end
    end
    return res;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    logic [7:0] l;
    l = b | 8'h20;
    return l >= "a" && l <= "z";
  endfunction

  function automatic logic is_word(input logic [7:0] b);
    return is_alpha(b) || is_digit(b) || b == "_";
  endfunction

  // Bit 6 flags a one-character operator; low bits give its kind.
  function automatic logic [6:0] single_kind(input logic [7:0] b);
    logic [6:0] k;
    unique case (b)
      "+": k = {1'b1, K_PLUS};
      "-": k = {1'b1, K_MINUS};
      "*": k = {1'b1, K_STAR};
      ";": k = {1'b1, K_SEMI};
      ":": k = {1'b1, K_COLON};
      ",": k = {1'b1, K_COMMA};
      ".": k = {1'b1, K_DOT};
      "?": k = {1'b1, K_QUEST};
      "(": k = {1'b1, K_LPAR};
      ")": k = {1'b1, K_RPAR};
      "{": k = {1'b1, K_LBRACE};
      "}": k = {1'b1, K_RBRACE};
      "[": k = {1'b1, K_LBRACK};
      "]": k = {1'b1, K_RBRACK};
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] str_escape(input logic [7:0] b);
    logic [7:0] r;
    unique case (b)
      "n": r = 8'h0A;
      "t": r = 8'h09;
      "r": r = 8'h0D;
      default: r = b;
    endcase
    return r;
  endfunction

  function automatic res_t mk_res(input logic [1:0] cls, input logic [5:0] kind,
                                  input logic [7:0] pay, input logic [31:0] val,
                                  input logic [2:0] err, input logic [15:0] line,
                                  input logic [15:0] col);
    res_t r;
    r.cls  = cls;
    r.kind = kind;
    r.pay  = pay;
    r.val  = val;
    r.err  = err;
    r.line = line;
    r.col  = col;
    return r;
  endfunction

endpackage

// ===== rtl/core/stt_if.sv =====
interface stt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;
  modport source(output valid, text_byte, end_of_text, input ready);
  modport sink(input valid, text_byte, end_of_text, output ready);
endinterface

interface stt_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         item_class;
  logic [5:0]         token_kind;
  logic [7:0]         payload_byte;
  logic signed [31:0] literal_value;
  logic [2:0]         error_code;
  logic [15:0]        line_number;
  logic [15:0]        column_number;
  logic               last_of_run;
  modport source(output valid, item_class, token_kind, payload_byte, literal_value,
                 error_code, line_number, column_number, last_of_run, input ready);
  modport sink(input valid, item_class, token_kind, payload_byte, literal_value,
               error_code, line_number, column_number, last_of_run, output ready);
endinterface

// ===== rtl/core/stt_front.sv =====
module stt_front #(
  parameter int POSITION_BITS = 16,
  parameter int KEYWORD_CHARS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             acc_i,
  input  logic [7:0]       byte_i,
  input  logic             eot_i,
  output stt_pkg::bundle_t bundle_o,
  output logic             push_o
);
  import stt_pkg::*;

  localparam int WLW = $clog2(KEYWORD_CHARS + 2);
  localparam int WIW = $clog2(KEYWORD_CHARS);
  localparam logic [POSITION_BITS-1:0] ONE = 1;
  localparam logic [POSITION_BITS-1:0] PMAX = '1;
  localparam logic [WLW-1:0] KC = WLW'(KEYWORD_CHARS);

  lex_mode_e mode_q, mode_d;
  logic [7:0] pend_q, pend_d, chv_q, chv_d;
  logic [POSITION_BITS-1:0] line_q, line_d, col_q, col_d, tsc_q, tsc_d, dotc;
  logic [31:0] acc_q, acc_d;
  logic [7:0] wbuf_q [KEYWORD_CHARS];
  logic [7:0] wbuf_d [KEYWORD_CHARS];
  logic [WLW-1:0] wlen_q, wlen_d;

  logic [6:0][7:0] wfirst;
  kw_t kw;
  logic [5:0] fw_kind;
  logic [31:0] fw_val;

  logic [7:0] b, sc;
  logic op_hit, op_emit, op_fault;
  logic [5:0] op_kind;
  logic [2:0] op_err;
  lex_mode_e op_mode;

  res_t [MAXRES-1:0] r;
  logic [2:0] n;
  logic redo, lbrk;
  logic [15:0] ln;
  logic [6:0] sk;

  assign b = byte_i;

  // Keyword match on the first characters of the buffered word.
  always_comb begin
    for (int j = 0; j < 7; j++) wfirst[j] = wbuf_q[j];
    kw = kw_lookup(wfirst, wlen_q[2:0]);
    if (wlen_q <= WLW'(7) && kw.hit) begin
      fw_kind = kw.kind;
      fw_val  = {31'b0, kw.val};
    end else begin
      fw_kind = K_IDENT;
      fw_val  = '0;
    end
  end

  // Completion of a pending operator against its second character.
  always_comb begin
    sc       = eot_i ? 8'h00 : b;
    op_hit   = 1'b0;
    op_emit  = 1'b1;
    op_fault = 1'b0;
    op_kind  = K_ASSIGN;
    op_err   = ERR_LONE_AMP;
    op_mode  = M_IDLE;
    unique case (pend_q)
      "=": begin op_hit = (sc == "="); op_kind = op_hit ? K_EQ : K_ASSIGN; end
      "!": begin op_hit = (sc == "="); op_kind = op_hit ? K_NE : K_NOT; end
      "<": begin op_hit = (sc == "="); op_kind = op_hit ? K_LE : K_LT; end
      ">": begin op_hit = (sc == "="); op_kind = op_hit ? K_GE : K_GT; end
      "&": begin
        op_hit = (sc == "&"); op_kind = K_AND;
        op_fault = !op_hit; op_err = ERR_LONE_AMP;
      end
      "|": begin
        op_hit = (sc == "|"); op_kind = K_OR;
        op_fault = !op_hit; op_err = ERR_LONE_PIPE;
      end
      "/": begin
        op_kind = K_SLASH;
        if (sc == "/") begin
          op_hit = 1'b1; op_emit = 1'b0; op_mode = M_LINE;
        end else if (sc == "*") begin
          op_hit = 1'b1; op_emit = 1'b0; op_mode = M_BLOCK;
        end
      end
      default: op_emit = 1'b0;
    endcase
  end

  assign dotc = (col_q > ONE) ? col_q - ONE : ONE;

  always_comb begin
    mode_d = mode_q;
    pend_d = pend_q;
    chv_d  = chv_q;
    line_d = line_q;
    col_d  = col_q;
    tsc_d  = tsc_q;
    acc_d  = acc_q;
    wbuf_d = wbuf_q;
    wlen_d = wlen_q;
    r      = '0;
    n      = '0;
    redo   = 1'b0;
    lbrk   = 1'b0;
    sk     = single_kind(b);
    ln     = 16'(line_q);
    if (eot_i) begin
      unique case (mode_q)
        M_WORD: begin
          r[n[1:0]] = mk_res(CLS_TOKEN, fw_kind, 8'h00, fw_val, 3'd0, ln, 16'(tsc_q));
          n = n + 3'd1;
        end
        M_INT: begin
          r[n[1:0]] = mk_res(CLS_TOKEN, K_INT, 8'h00, acc_q, 3'd0, ln, 16'(tsc_q));
          n = n + 3'd1;
        end
        M_INT_DOT: begin
          r[n[1:0]] = mk_res(CLS_TOKEN, K_INT, 8'h00, acc_q, 3'd0, ln, 16'(tsc_q));
          n = n + 3'd1;
          r[n[1:0]] = mk_res(CLS_TOKEN, K_DOT, 8'h00, '0, 3'd0, ln, 16'(dotc));
          n = n + 3'd1;
        end
        M_FLOAT: begin
          r[n[1:0]] = mk_res(CLS_TOKEN, K_FLOAT, 8'h00, '0, 3'd0, ln, 16'(tsc_q));
          n = n + 3'd1;
        end
        M_STR, M_STR_ESC: begin
          r[n[1:0]] = mk_res(CLS_ERROR, 6'd0, 8'h00, '0, ERR_OPEN_STR, ln, 16'(tsc_q));
          n = n + 3'd1;
        end
        M_CHR, M_CHR_ESC, M_CHR_END: begin
          if (mode_q == M_CHR_ESC) begin
            r[n[1:0]] = mk_res(CLS_ERROR, 6'd0, 8'h00, '0, ERR_BAD_ESC, ln, 16'(col_q));
            n = n + 3'd1;
          end
          r[n[1:0]] = mk_res(CLS_ERROR, 6'd0, 8'h00, '0, ERR_OPEN_CHR, ln, 16'(tsc_q));
          n = n + 3'd1;
          r[n[1:0]] = mk_res(CLS_TOKEN, K_CHAR, 8'h00,
                             (mode_q == M_CHR_END) ? {24'b0, chv_q} : 32'b0,
                             3'd0, ln, 16'(tsc_q));
          n = n + 3'd1;
        end
        M_OP: begin
          if (op_emit) begin
            r[n[1:0]] = op_fault
              ? mk_res(CLS_ERROR, 6'd0, 8'h00, '0, op_err, ln, 16'(tsc_q))
              : mk_res(CLS_TOKEN, op_kind, 8'h00, '0, 3'd0, ln, 16'(tsc_q));
            n = n + 3'd1;
          end
        end
        default: ;
      endcase
      r[n[1:0]] = mk_res(CLS_TOKEN, K_EOF, 8'h00, '0, 3'd0, ln, 16'(col_q));
      n = n + 3'd1;
      mode_d = M_IDLE;
      pend_d = '0;
      chv_d  = '0;
      line_d = ONE;
      col_d  = ONE;
      tsc_d  = ONE;
      acc_d  = '0;
      wlen_d = '0;
    end else begin
      unique case (mode_q)
        M_WORD: begin
          if (is_word(b)) begin
            if (wlen_q < KC) wbuf_d[wlen_q[WIW-1:0]] = b;
            if (wlen_q <= KC) wlen_d = wlen_q + WLW'(1);
            r[n[1:0]] = mk_res(CLS_TEXT, 6'd0, b, '0, 3'd0, ln, 16'(tsc_q));
            n = n + 3'd1;
          end else begin
            r[n[1:0]] = mk_res(CLS_TOKEN, fw_kind, 8'h00, fw_val, 3'd0, ln, 16'(tsc_q));
            n = n + 3'd1;
            redo = 1'b1;
          end
        end
        M_INT: begin
          if (is_digit(b)) begin
            acc_d = acc_q * 32'd10 + {24'b0, 8'(b - 8'h30)};
            r[n[1:0]] = mk_res(CLS_TEXT, 6'd0, b, '0, 3'd0, ln, 16'(tsc_q));
            n = n + 3'd1;
          end else if (b == ".") begin
            mode_d = M_INT_DOT;
          end else begin
            r[n[1:0]] = mk_res(CLS_TOKEN, K_INT, 8'h00, acc_q, 3'd0, ln, 16'(tsc_q));
            n = n + 3'd1;
            redo = 1'b1;
          end
        end
        M_INT_DOT: begin
          if (is_digit(b)) begin
            r[n[1:0]] = mk_res(CLS_TEXT, 6'd0, ".", '0, 3'd0, ln, 16'(tsc_q));
            n = n + 3'd1;
            r[n[1:0]] = mk_res(CLS_TEXT, 6'd0, b, '0, 3'd0, ln, 16'(tsc_q));
            n = n + 3'd1;
            mode_d = M_FLOAT;
          end else begin
            r[n[1:0]] = mk_res(CLS_TOKEN, K_INT, 8'h00, acc_q, 3'd0, ln, 16'(tsc_q));
            n = n + 3'd1;
            r[n[1:0]] = mk_res(CLS_TOKEN, K_DOT, 8'h00, '0, 3'd0, ln, 16'(dotc));
            n = n + 3'd1;
            redo = 1'b1;
          end
        end
        M_FLOAT: begin
          if (is_digit(b)) begin
            r[n[1:0]] = mk_res(CLS_TEXT, 6'd0, b, '0, 3'd0, ln, 16'(tsc_q));
            n = n + 3'd1;
          end else if (b == "f" || b == "F") begin
            r[n[1:0]] = mk_res(CLS_TEXT, 6'd0, b, '0, 3'd0, ln, 16'(tsc_q));
            n = n + 3'd1;
            r[n[1:0]] = mk_res(CLS_TOKEN, K_FLOAT, 8'h00, '0, 3'd0, ln, 16'(tsc_q));
            n = n + 3'd1;
            mode_d = M_IDLE;
          end else begin
            r[n[1:0]] = mk_res(CLS_TOKEN, K_FLOAT, 8'h00, '0, 3'd0, ln, 16'(tsc_q));
            n = n + 3'd1;
            redo = 1'b1;
          end
        end
        M_STR: begin
          if (b == 8'h22) begin
            r[n[1:0]] = mk_res(CLS_TOKEN, K_STR, 8'h00, '0, 3'd0, ln, 16'(tsc_q));
            n = n + 3'd1;
            mode_d = M_IDLE;
          end else if (b == 8'h0A) begin
            r[n[1:0]] = mk_res(CLS_ERROR, 6'd0, 8'h00, '0, ERR_OPEN_STR, ln, 16'(tsc_q));
            n = n + 3'd1;
            redo = 1'b1;
          end else if (b == 8'h5C) begin
            mode_d = M_STR_ESC;
          end else begin
            r[n[1:0]] = mk_res(CLS_TEXT, 6'd0, b, '0, 3'd0, ln, 16'(tsc_q));
            n = n + 3'd1;
          end
        end
        M_STR_ESC: begin
          r[n[1:0]] = mk_res(CLS_TEXT, 6'd0, str_escape(b), '0, 3'd0, ln, 16'(tsc_q));
          n = n + 3'd1;
          mode_d = M_STR;
        end
        M_CHR: begin
          if (b == 8'h5C) begin
            mode_d = M_CHR_ESC;
          end else begin
            chv_d  = b;
            mode_d = M_CHR_END;
          end
        end
        M_CHR_ESC: begin
          mode_d = M_CHR_END;
          priority if (b == "n") chv_d = 8'h0A;
          else if (b == "t") chv_d = 8'h09;
          else if (b == "r") chv_d = 8'h0D;
          else if (b == "0") chv_d = 8'h00;
          else if (b == 8'h5C || b == 8'h27) chv_d = b;
          else begin
            r[n[1:0]] = mk_res(CLS_ERROR, 6'd0, 8'h00, '0, ERR_BAD_ESC, ln, 16'(col_q));
            n = n + 3'd1;
            chv_d = b;
          end
        end
        M_CHR_END: begin
          if (b == 8'h27) begin
            r[n[1:0]] = mk_res(CLS_TOKEN, K_CHAR, 8'h00, {24'b0, chv_q}, 3'd0, ln,
                               16'(tsc_q));
            n = n + 3'd1;
            mode_d = M_IDLE;
          end else begin
            r[n[1:0]] = mk_res(CLS_ERROR, 6'd0, 8'h00, '0, ERR_OPEN_CHR, ln, 16'(tsc_q));
            n = n + 3'd1;
            r[n[1:0]] = mk_res(CLS_TOKEN, K_CHAR, 8'h00, {24'b0, chv_q}, 3'd0, ln,
                               16'(tsc_q));
            n = n + 3'd1;
            redo = 1'b1;
          end
        end
        M_OP: begin
          if (op_emit) begin
            r[n[1:0]] = op_fault
              ? mk_res(CLS_ERROR, 6'd0, 8'h00, '0, op_err, ln, 16'(tsc_q))
              : mk_res(CLS_TOKEN, op_kind, 8'h00, '0, 3'd0, ln, 16'(tsc_q));
            n = n + 3'd1;
          end
          mode_d = op_mode;
          redo   = !op_hit;
        end
        M_LINE: redo = (b == 8'h0A);
        M_BLOCK: begin
          if (b == "*") mode_d = M_BLOCK_STAR;
          else if (b == 8'h0A) lbrk = 1'b1;
        end
        M_BLOCK_STAR: begin
          if (b == "/") mode_d = M_IDLE;
          else if (b == 8'h0A) begin
            lbrk   = 1'b1;
            mode_d = M_BLOCK;
          end else if (b != "*") mode_d = M_BLOCK;
        end
        default: redo = 1'b1;
      endcase

      // Lex the byte afresh from the idle mode.
      if (redo) begin
        mode_d = M_IDLE;
        if (b == 8'h0A) begin
          lbrk = 1'b1;
        end else if (b == 8'h20 || b == 8'h09 || b == 8'h0D) begin
          mode_d = M_IDLE;
        end else begin
          tsc_d = col_q;
          if (is_digit(b)) begin
            acc_d = {24'b0, 8'(b - 8'h30)};
            r[n[1:0]] = mk_res(CLS_TEXT, 6'd0, b, '0, 3'd0, ln, 16'(col_q));
            n = n + 3'd1;
            mode_d = M_INT;
          end else if (b == 8'h22) begin
            mode_d = M_STR;
          end else if (b == 8'h27) begin
            mode_d = M_CHR;
          end else if (is_alpha(b) || b == "_") begin
            wbuf_d[0] = b;
            wlen_d    = WLW'(1);
            r[n[1:0]] = mk_res(CLS_TEXT, 6'd0, b, '0, 3'd0, ln, 16'(col_q));
            n = n + 3'd1;
            mode_d = M_WORD;
          end else if (b == "=" || b == "!" || b == "<" || b == ">" ||
                       b == "&" || b == "|" || b == "/") begin
            pend_d = b;
            mode_d = M_OP;
          end else if (sk[6]) begin
            r[n[1:0]] = mk_res(CLS_TOKEN, sk[5:0], 8'h00, '0, 3'd0, ln, 16'(col_q));
            n = n + 3'd1;
          end else begin
            r[n[1:0]] = mk_res(CLS_ERROR, 6'd0, 8'h00, '0, ERR_BAD_CHAR, ln, 16'(col_q));
            n = n + 3'd1;
          end
        end
      end

      // Advance the position, saturating.
      if (lbrk) begin
        if (line_q != PMAX) line_d = line_q + ONE;
        col_d = ONE;
      end else if (col_q != PMAX) begin
        col_d = col_q + ONE;
      end
    end
  end

  assign bundle_o.r = r;
  assign bundle_o.n = n;
  assign push_o     = acc_i && (n != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      pend_q <= '0;
      chv_q  <= '0;
      line_q <= ONE;
      col_q  <= ONE;
      tsc_q  <= ONE;
      acc_q  <= '0;
      wlen_q <= '0;
    end else if (acc_i) begin
      mode_q <= mode_d;
      pend_q <= pend_d;
      chv_q  <= chv_d;
      line_q <= line_d;
      col_q  <= col_d;
      tsc_q  <= tsc_d;
      acc_q  <= acc_d;
      wlen_q <= wlen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) wbuf_q <= wbuf_d;
  end

endmodule

// ===== rtl/core/stt_queue.sv =====
module stt_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  stt_pkg::bundle_t bundle_i,
  input  logic             pop_i,
  output stt_pkg::bundle_t head_o,
  output logic             full_o,
  output logic             empty_o,
  output logic [$clog2(stt_pkg::QDEPTH+1)-1:0] count_o
);
  import stt_pkg::*;

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  bundle_t mem_q [QDEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [CW-1:0] cnt_q;

  assign head_o  = mem_q[rp_q];
  assign full_o  = (cnt_q == CW'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= bundle_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == PW'(QDEPTH - 1)) ? '0 : wp_q + PW'(1);
      if (pop_i)  rp_q <= (rp_q == PW'(QDEPTH - 1)) ? '0 : rp_q + PW'(1);
      cnt_q <= cnt_q + CW'(push_i) - CW'(pop_i);
    end
  end

endmodule

// ===== rtl/core/stt_back.sv =====
module stt_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             avail_i,
  input  stt_pkg::bundle_t head_i,
  output logic             pop_o,
  stt_out_if.source        tok_o
);
  import stt_pkg::*;

  logic [1:0] idx_q;
  logic       last;
  res_t       cur;

  assign cur  = head_i.r[idx_q];
  assign last = ({1'b0, idx_q} == head_i.n - 3'd1);

  assign tok_o.valid         = avail_i;
  assign tok_o.item_class    = cur.cls;
  assign tok_o.token_kind    = cur.kind;
  assign tok_o.payload_byte  = cur.pay;
  assign tok_o.literal_value = cur.val;
  assign tok_o.error_code    = cur.err;
  assign tok_o.line_number   = cur.line;
  assign tok_o.column_number = cur.col;
  assign tok_o.last_of_run   = last;

  assign pop_o = avail_i && tok_o.ready && last;

  // Step through the results of the head bundle, then drop it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (avail_i && tok_o.ready) begin
      idx_q <= last ? 2'd0 : idx_q + 2'd1;
    end
  end

endmodule

// ===== rtl/core/source_text_tokenizer.sv =====
// Source text tokenizer.
// text_i takes one source byte per item (text_byte), or an end marker
// (end_of_text) that flushes any pending token, emits EOF and returns the
// lexer to its reset state. tok_o gives result items: tokens, payload text
// bytes that precede their token, and error reports, each with the line and
// column where it starts; last_of_run marks the final result of one byte.
// The front lexer classifies one byte per cycle while the queue has room;
// any results of that byte (up to four) go as one bundle into a two-entry
// queue, and the back end unpacks the head bundle at one result per cycle
// while tok_o is ready. Throughput: one byte per cycle while the queue has
// room; a byte with k results holds the output until all k have drained,
// so the sustained rate is set by the output drain.
// The results of a byte enter the queue when the byte is accepted.
// Reset: lexer idle at line 1, column 1, queue empty, no output valid.
// A stalled receiver holds the current result; the queue fills and text_i
// ready drops until space frees. Bytes that cause no result never wait on
// the output side unless the queue is full.
module source_text_tokenizer #(
  parameter int POSITION_BITS = 16,
  parameter int KEYWORD_CHARS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  stt_in_if.sink     text_i,
  stt_out_if.source  tok_o
);
  import stt_pkg::*;

  localparam int CW = $clog2(QDEPTH + 1);

  bundle_t       bundle, head;
  logic          push, pop, full, empty, acc;
  logic [CW-1:0] count;

  // Accept bytes whenever the queue can hold another bundle.
  assign text_i.ready = !full;
  assign acc          = text_i.valid && text_i.ready;

  stt_front #(
    .POSITION_BITS(POSITION_BITS),
    .KEYWORD_CHARS(KEYWORD_CHARS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (acc),
    .byte_i   (text_i.text_byte),
    .eot_i    (text_i.end_of_text),
    .bundle_o (bundle),
    .push_o   (push)
  );

  stt_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .bundle_i (bundle),
    .pop_i    (pop),
    .head_o   (head),
    .full_o   (full),
    .empty_o  (empty),
    .count_o  (count)
  );

  stt_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (!empty),
    .head_i  (head),
    .pop_o   (pop),
    .tok_o   (tok_o)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CW'(QDEPTH)) else $error("queue count above depth");

  a_empty_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count == '0 |-> !tok_o.valid) else $error("output valid with empty queue");

  a_eof_pushed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && text_i.end_of_text |-> push) else $error("end marker without results");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> count == $past(count) + CW'($past(push)) - CW'($past(pop)))
    else $error("queue count mismatch");

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  import stt_pkg::*;

  // Run limit in cycles: about 270 bytes, up to four results each, receiver
  // stalls, sender gaps and one long hold.
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned POS_MAX     = 65535;
  localparam int          WORD_CHARS  = 8;
  localparam int          HOLD_CYCLES = 300;

  // Byte codes that have no printable literal form.
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_DQ   = 8'h22;
  localparam logic [7:0] CH_APOS = 8'h27;
  localparam logic [7:0] CH_BSL  = 8'h5C;

  typedef struct {
    res_t r;
    logic last;
  } result_exp_t;

  typedef struct {
    logic [7:0] b;
    logic       e;
  } text_item_t;

  // One row of the directed table; when chk is set the first result of the
  // byte must carry the typed class, kind, error code and value.
  typedef struct {
    logic [7:0]  b;
    logic        e;
    logic        chk;
    logic [1:0]  cls;
    logic [5:0]  kind;
    logic [2:0]  err;
    logic [31:0] val;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  stt_in_if  text_if ();
  stt_out_if tok_if ();

  source_text_tokenizer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .text_i (text_if),
    .tok_o  (tok_if)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------
  // Lexer shadow state
  // ---------------------------------------------------------------------
  lex_mode_e   lx_mode;
  logic [7:0]  op_first;
  int unsigned cur_line;
  int unsigned cur_col;
  int unsigned tok_col;
  logic [31:0] num_acc;
  logic [7:0]  chr_val;
  logic [7:0]  word_buf [WORD_CHARS];
  int unsigned word_len;
  bit          line_brk;

  res_t        run_res[$];   // results of the byte being lexed
  result_exp_t pending_res[$];

  string       kw_text [28] = '{
    "if", "else", "int", "char", "void", "null", "bool", "string", "def",
    "include", "extern", "while", "do", "for", "to", "return", "alloc",
    "free", "match", "some", "own", "ref", "const", "float", "double",
    "true", "false", "_"};
  int unsigned kw_kind [28] = '{
    7, 8, 9, 10, 11, 5, 12, 13, 14, 15, 16, 17, 18, 19, 20, 21, 22, 23, 24,
    25, 26, 27, 28, 29, 30, 4, 4, 31};

  int failures;
  int n_tokens;
  int n_texts;
  int n_errors;
  int n_items;
  int n_ends;

  function automatic bit is_dig(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_let(logic [7:0] b);
    logic [7:0] l;
    l = b | 8'h20;
    return l >= "a" && l <= "z";
  endfunction

  function void lex_clear();
    lx_mode  = M_IDLE;
    op_first = '0;
    cur_line = 1;
    cur_col  = 1;
    tok_col  = 1;
    num_acc  = '0;
    chr_val  = '0;
    word_len = 0;
  endfunction

  function void emit(logic [1:0] cls, logic [5:0] kind, logic [7:0] pay,
                     logic [31:0] val, logic [2:0] err, int unsigned line,
                     int unsigned col);
    res_t r;
    if (run_res.size() < MAXRES) begin
      r.cls  = cls;
      r.kind = kind;
      r.pay  = pay;
      r.val  = val;
      r.err  = err;
      r.line = line[15:0];
      r.col  = col[15:0];
      run_res.push_back(r);
    end
  endfunction

  function void put_token(logic [5:0] kind, logic [31:0] val);
    emit(CLS_TOKEN, kind, '0, val, '0, cur_line, tok_col);
  endfunction

  function void put_text(logic [7:0] b);
    emit(CLS_TEXT, '0, b, '0, '0, cur_line, tok_col);
  endfunction

  function void put_error(logic [2:0] code, int unsigned col);
    emit(CLS_ERROR, '0, '0, '0, code, cur_line, col);
  endfunction

  function void put_dot();
    emit(CLS_TOKEN, K_DOT, '0, '0, '0, cur_line, cur_col > 1 ? cur_col - 1 : 1);
  endfunction

  // Match the collected word against the keyword list.
  function void close_word();
    bit same;
    if (word_len <= WORD_CHARS) begin
      for (int k = 0; k < 28; k++) begin
        if (kw_text[k].len() == word_len) begin
          same = 1;
          for (int j = 0; j < word_len; j++)
            if (kw_text[k][j] != word_buf[j]) same = 0;
          if (same) begin
            put_token(kw_kind[k][5:0], k == 25 ? 32'd1 : 32'd0);
            return;
          end
        end
      end
    end
    put_token(K_IDENT, '0);
  endfunction

  function automatic bit single_op(logic [7:0] b, output logic [5:0] k);
    case (b)
      "+": k = K_PLUS;
      "-": k = K_MINUS;
      "*": k = K_STAR;
      ";": k = K_SEMI;
      ":": k = K_COLON;
      ",": k = K_COMMA;
      ".": k = K_DOT;
      "?": k = K_QUEST;
      "(": k = K_LPAR;
      ")": k = K_RPAR;
      "{": k = K_LBRACE;
      "}": k = K_RBRACE;
      "[": k = K_LBRACK;
      "]": k = K_RBRACK;
      default: begin
        k = '0;
        return 0;
      end
    endcase
    return 1;
  endfunction

  // Start a fresh token from the idle mode.
  function void lex_fresh(logic [7:0] b);
    logic [5:0] k;
    lx_mode = M_IDLE;
    if (b == CH_NL) begin
      line_brk = 1;
      return;
    end
    if (b == " " || b == CH_TAB || b == CH_CR) return;
    tok_col = cur_col;
    if (is_dig(b)) begin
      num_acc = 32'(b - "0");
      put_text(b);
      lx_mode = M_INT;
    end else if (b == CH_DQ) begin
      lx_mode = M_STR;
    end else if (b == CH_APOS) begin
      lx_mode = M_CHR;
    end else if (is_let(b) || b == "_") begin
      word_buf[0] = b;
      word_len    = 1;
      put_text(b);
      lx_mode = M_WORD;
    end else if (b == "=" || b == "!" || b == "<" || b == ">" || b == "&" ||
                 b == "|" || b == "/") begin
      op_first = b;
      lx_mode  = M_OP;
    end else if (single_op(b, k)) begin
      put_token(k, '0);
    end else begin
      put_error(ERR_BAD_CHAR, tok_col);
    end
  endfunction

  // Finish a pending operator; return 1 when b was consumed as its second char.
  function bit close_op(logic [7:0] b);
    lx_mode = M_IDLE;
    case (op_first)
      "=": begin put_token(b == "=" ? K_EQ : K_ASSIGN, '0); return b == "="; end
      "!": begin put_token(b == "=" ? K_NE : K_NOT, '0); return b == "="; end
      "<": begin put_token(b == "=" ? K_LE : K_LT, '0); return b == "="; end
      ">": begin put_token(b == "=" ? K_GE : K_GT, '0); return b == "="; end
      "&": begin
        if (b == "&") put_token(K_AND, '0);
        else put_error(ERR_LONE_AMP, tok_col);
        return b == "&";
      end
      "|": begin
        if (b == "|") put_token(K_OR, '0);
        else put_error(ERR_LONE_PIPE, tok_col);
        return b == "|";
      end
      "/": begin
        if (b == "/") begin
          lx_mode = M_LINE;
          return 1;
        end
        if (b == "*") begin
          lx_mode = M_BLOCK;
          return 1;
        end
        put_token(K_SLASH, '0);
        return 0;
      end
      default: return 0;
    endcase
  endfunction

  function void lex_byte(logic [7:0] b);
    case (lx_mode)
      M_WORD: begin
        if (is_let(b) || is_dig(b) || b == "_") begin
          if (word_len < WORD_CHARS) word_buf[word_len] = b;
          if (word_len <= WORD_CHARS) word_len++;
          put_text(b);
        end else begin
          close_word();
          lex_fresh(b);
        end
      end
      M_INT: begin
        if (is_dig(b)) begin
          num_acc = num_acc * 10 + 32'(b - "0");
          put_text(b);
        end else if (b == ".") begin
          lx_mode = M_INT_DOT;
        end else begin
          put_token(K_INT, num_acc);
          lex_fresh(b);
        end
      end
      M_INT_DOT: begin
        if (is_dig(b)) begin
          put_text(".");
          put_text(b);
          lx_mode = M_FLOAT;
        end else begin
          put_token(K_INT, num_acc);
          put_dot();
          lex_fresh(b);
        end
      end
      M_FLOAT: begin
        if (is_dig(b)) begin
          put_text(b);
        end else if (b == "f" || b == "F") begin
          put_text(b);
          put_token(K_FLOAT, '0);
          lx_mode = M_IDLE;
        end else begin
          put_token(K_FLOAT, '0);
          lex_fresh(b);
        end
      end
      M_STR: begin
        if (b == CH_DQ) begin
          put_token(K_STR, '0);
          lx_mode = M_IDLE;
        end else if (b == CH_NL) begin
          put_error(ERR_OPEN_STR, tok_col);
          lex_fresh(b);
        end else if (b == CH_BSL) begin
          lx_mode = M_STR_ESC;
        end else begin
          put_text(b);
        end
      end
      M_STR_ESC: begin
        put_text(b == "n" ? CH_NL : b == "t" ? CH_TAB : b == "r" ? CH_CR : b);
        lx_mode = M_STR;
      end
      M_CHR: begin
        if (b == CH_BSL) begin
          lx_mode = M_CHR_ESC;
        end else begin
          chr_val = b;
          lx_mode = M_CHR_END;
        end
      end
      M_CHR_ESC: begin
        if (b == "n") chr_val = CH_NL;
        else if (b == "t") chr_val = CH_TAB;
        else if (b == "r") chr_val = CH_CR;
        else if (b == "0") chr_val = '0;
        else if (b == CH_BSL || b == CH_APOS) chr_val = b;
        else begin
          put_error(ERR_BAD_ESC, cur_col);
          chr_val = b;
        end
        lx_mode = M_CHR_END;
      end
      M_CHR_END: begin
        if (b == CH_APOS) begin
          put_token(K_CHAR, 32'(chr_val));
          lx_mode = M_IDLE;
        end else begin
          put_error(ERR_OPEN_CHR, tok_col);
          put_token(K_CHAR, 32'(chr_val));
          lex_fresh(b);
        end
      end
      M_OP: begin
        if (!close_op(b)) lex_fresh(b);
      end
      M_LINE: begin
        if (b == CH_NL) lex_fresh(b);
      end
      M_BLOCK: begin
        if (b == "*") lx_mode = M_BLOCK_STAR;
        else if (b == CH_NL) line_brk = 1;
      end
      M_BLOCK_STAR: begin
        if (b == "/") lx_mode = M_IDLE;
        else if (b == CH_NL) begin
          line_brk = 1;
          lx_mode  = M_BLOCK;
        end else if (b != "*") lx_mode = M_BLOCK;
      end
      default: lex_fresh(b);
    endcase
  endfunction

  // Flush whatever is open at the end marker, then EOF.
  function void close_text();
    case (lx_mode)
      M_WORD:    close_word();
      M_INT:     put_token(K_INT, num_acc);
      M_INT_DOT: begin
        put_token(K_INT, num_acc);
        put_dot();
      end
      M_FLOAT:   put_token(K_FLOAT, '0);
      M_STR, M_STR_ESC: put_error(ERR_OPEN_STR, tok_col);
      M_CHR: begin
        put_error(ERR_OPEN_CHR, tok_col);
        put_token(K_CHAR, '0);
      end
      M_CHR_ESC: begin
        put_error(ERR_BAD_ESC, cur_col);
        put_error(ERR_OPEN_CHR, tok_col);
        put_token(K_CHAR, '0);
      end
      M_CHR_END: begin
        put_error(ERR_OPEN_CHR, tok_col);
        put_token(K_CHAR, 32'(chr_val));
      end
      M_OP: void'(close_op('0));
      default: ;
    endcase
    emit(CLS_TOKEN, K_EOF, '0, '0, '0, cur_line, cur_col);
  endfunction

  // Lex one accepted item and queue the results it must cause.
  function void tokenize_item(logic [7:0] b, logic e);
    result_exp_t x;
    run_res.delete();
    line_brk = 0;
    if (e) begin
      close_text();
      lex_clear();
    end else begin
      lex_byte(b);
      if (line_brk) begin
        if (cur_line < POS_MAX) cur_line++;
        cur_col = 1;
      end else if (cur_col < POS_MAX) begin
        cur_col++;
      end
    end
    foreach (run_res[i]) begin
      x.r    = run_res[i];
      x.last = (i == run_res.size() - 1);
      pending_res.push_back(x);
    end
  endfunction

  // ---------------------------------------------------------------------
  // Sender: bursts of items with random gaps
  // ---------------------------------------------------------------------
  int burst_left;

  task automatic send_item(input logic [7:0] b, input logic e);
    int gap;
    text_if.valid       <= 1'b1;
    text_if.text_byte   <= b;
    text_if.end_of_text <= e;
    do @(posedge clk_i); while (!text_if.ready);
    tokenize_item(b, e);
    n_items++;
    if (e) n_ends++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // drop valid for a gap, then start a new burst
      gap = $urandom_range(1, 6);
      text_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(0, 20);
    end
  endtask

  // ---------------------------------------------------------------------
  // Receiver: stall pattern redrawn at random; one long hold-off
  // ---------------------------------------------------------------------
  bit          rx_hold;
  int unsigned rx_cycle;
  int unsigned rx_style;

  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 64 == 0) rx_style <= $urandom_range(0, 2);
    if (rx_hold) tok_if.ready <= 1'b0;
    else begin
      case (rx_style)
        0:       tok_if.ready <= 1'b1;
        1:       tok_if.ready <= ($urandom_range(0, 3) != 0);
        default: tok_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Hold the output for a long stretch once traffic is flowing, so the
  // result queue fills and the input side must stall.
  initial begin
    rx_hold = 0;
    wait (n_items >= 60);
    @(posedge clk_i);
    rx_hold = 1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold = 0;
  end

  // ---------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    result_exp_t x;
    if (rst_ni && tok_if.valid && tok_if.ready) begin
      if (pending_res.size() == 0) begin
        $error("unexpected result: class %0d kind %0d", tok_if.item_class,
               tok_if.token_kind);
        failures++;
      end else begin
        x = pending_res.pop_front();
        if (tok_if.item_class !== x.r.cls) begin
          $error("item_class: expected %0d, got %0d", x.r.cls, tok_if.item_class);
          failures++;
        end
        if (tok_if.token_kind !== x.r.kind) begin
          $error("token_kind: expected %0d, got %0d", x.r.kind, tok_if.token_kind);
          failures++;
        end
        if (tok_if.payload_byte !== x.r.pay) begin
          $error("payload_byte: expected %0h, got %0h", x.r.pay, tok_if.payload_byte);
          failures++;
        end
        if (tok_if.literal_value !== x.r.val) begin
          $error("literal_value: expected %0d, got %0d", $signed(x.r.val),
                 tok_if.literal_value);
          failures++;
        end
        if (tok_if.error_code !== x.r.err) begin
          $error("error_code: expected %0d, got %0d", x.r.err, tok_if.error_code);
          failures++;
        end
        if (tok_if.line_number !== x.r.line) begin
          $error("line_number: expected %0d, got %0d", x.r.line, tok_if.line_number);
          failures++;
        end
        if (tok_if.column_number !== x.r.col) begin
          $error("column_number: expected %0d, got %0d", x.r.col,
                 tok_if.column_number);
          failures++;
        end
        if (tok_if.last_of_run !== x.last) begin
          $error("last_of_run: expected %0d, got %0d", x.last, tok_if.last_of_run);
          failures++;
        end
        case (x.r.cls)
          CLS_TOKEN: n_tokens++;
          CLS_TEXT:  n_texts++;
          default:   n_errors++;
        endcase
      end
    end
  end

  // Watchdog
  int unsigned cycles;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  dir_row_t   dir_rows[$];
  text_item_t src_text[$];

  function void add_row(logic [7:0] b, logic e, logic chk, logic [1:0] cls,
                        logic [5:0] kind, logic [2:0] err, logic [31:0] val);
    dir_row_t r;
    r = '{b, e, chk, cls, kind, err, val};
    dir_rows.push_back(r);
  endfunction

  function void add_text(string s);
    text_item_t t;
    for (int i = 0; i < s.len(); i++) begin
      t.b = s[i];
      t.e = 1'b0;
      src_text.push_back(t);
    end
  endfunction

  function void add_byte(logic [7:0] b, logic e);
    text_item_t t;
    t.b = b;
    t.e = e;
    src_text.push_back(t);
  endfunction

  function automatic string rand_word(int n);
    string s;
    int    c;
    s = "";
    for (int i = 0; i < n; i++) begin
      c = $urandom_range(0, 37);
      if (c < 26) s = {s, string'(byte'("a" + c))};
      else if (c < 36 && i > 0) s = {s, string'(byte'("0" + c - 26))};
      else s = {s, "_"};
    end
    return s;
  endfunction

  function automatic string rand_digits(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(byte'("0" + $urandom_range(0, 9)))};
    return s;
  endfunction

  string op_list [18] = '{"==", "!=", "<=", ">=", "&&", "||", "=", "!", "<", ">",
                          "/", "+", "-", "*", "?", "(", ")", "[]"};

  // Append one random fragment of source text; most are well formed.
  function void add_fragment();
    int n;
    case ($urandom_range(0, 13))
      0, 1: add_text({kw_text[$urandom_range(0, 27)], " "});
      2: add_text(rand_word($urandom_range(1, 11)));
      3: begin
        add_text(rand_digits($urandom_range(1, 12)));
        add_text($urandom_range(0, 2) == 0 ? "." : ";");
      end
      4: begin
        add_text({rand_digits($urandom_range(1, 3)), ".", rand_digits($urandom_range(1, 3))});
        if ($urandom_range(0, 1)) add_text($urandom_range(0, 1) ? "f" : "F");
        add_text(" ");
      end
      5: begin
        add_byte(CH_DQ, 0);
        n = $urandom_range(0, 5);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 3) == 0) begin
            add_byte(CH_BSL, 0);
            add_byte(8'($urandom_range(0, 255)), 0);
          end else begin
            add_byte(8'($urandom_range(32, 126) == 34 ? "a" : $urandom_range(35, 126)), 0);
          end
        end
        add_byte(CH_DQ, 0);
      end
      6: begin
        add_byte(CH_APOS, 0);
        if ($urandom_range(0, 1)) begin
          add_byte(CH_BSL, 0);
          case ($urandom_range(0, 4))
            0: add_text("n");
            1: add_text("0");
            2: add_byte(CH_APOS, 0);
            3: add_byte(CH_BSL, 0);
            default: add_byte(8'($urandom_range(0, 255)), 0);
          endcase
        end else begin
          add_byte(8'($urandom_range(0, 255)), 0);
        end
        add_byte(CH_APOS, 0);
      end
      7: add_text({op_list[$urandom_range(0, 17)], " "});
      8: begin
        add_text({"// ", rand_word(3)});
        add_byte(CH_NL, 0);
      end
      9: begin
        add_text("/* ");
        add_text(rand_word(2));
        add_byte(CH_NL, 0);
        add_text("**/");
      end
      10: add_byte($urandom_range(0, 1) ? CH_NL : CH_TAB, 0);
      11: add_byte(8'($urandom_range(0, 255)), 0);
      12: begin
        // broken sequences: open string, open char, lone operators
        case ($urandom_range(0, 2))
          0: begin
            add_byte(CH_DQ, 0);
            add_text(rand_word(2));
            add_byte(CH_NL, 0);
          end
          1: add_text({"'", rand_word(2)});
          default: add_text($urandom_range(0, 1) ? "&x" : "|;");
        endcase
      end
      default: add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    endcase
  endfunction

  initial begin
    failures    = 0;
    n_tokens    = 0;
    n_texts     = 0;
    n_errors    = 0;
    n_items     = 0;
    n_ends      = 0;
    burst_left  = 0;
    lex_clear();
    rst_ni              = 1'b0;
    text_if.valid       = 1'b0;
    text_if.text_byte   = '0;
    text_if.end_of_text = 1'b0;

    // Directed part: bad chars, lone operators, number and dot, escapes,
    // open string and char, bytes 0 and 255, end marker in open states.
    add_row("@",     0, 1, CLS_ERROR, '0,      ERR_BAD_CHAR,  '0);
    add_row("&",     0, 0, '0, '0, '0, '0);
    add_row(" ",     0, 1, CLS_ERROR, '0,      ERR_LONE_AMP,  '0);
    add_row("|",     0, 0, '0, '0, '0, '0);
    add_row(";",     0, 1, CLS_ERROR, '0,      ERR_LONE_PIPE, '0);
    add_row("9",     0, 1, CLS_TEXT,  '0,      '0,            '0);
    add_row(".",     0, 0, '0, '0, '0, '0);
    add_row("x",     0, 1, CLS_TOKEN, K_INT,   '0,            32'd9);
    add_row(CH_APOS, 0, 0, '0, '0, '0, '0);
    add_row(CH_BSL,  0, 0, '0, '0, '0, '0);
    add_row("q",     0, 1, CLS_ERROR, '0,      ERR_BAD_ESC,   '0);
    add_row(CH_APOS, 0, 1, CLS_TOKEN, K_CHAR,  '0,            32'h71);
    add_row(CH_DQ,   0, 0, '0, '0, '0, '0);
    add_row(CH_NL,   0, 1, CLS_ERROR, '0,      ERR_OPEN_STR,  '0);
    add_row(8'hFF,   0, 1, CLS_ERROR, '0,      ERR_BAD_CHAR,  '0);
    add_row(8'h00,   0, 1, CLS_ERROR, '0,      ERR_BAD_CHAR,  '0);
    add_row(CH_APOS, 0, 0, '0, '0, '0, '0);
    add_row("a",     0, 0, '0, '0, '0, '0);
    add_row("b",     0, 1, CLS_ERROR, '0,      ERR_OPEN_CHR,  '0);
    add_row(8'hA5,   1, 1, CLS_TOKEN, K_IDENT, '0,            '0);
    add_row("/",     0, 0, '0, '0, '0, '0);
    add_row("*",     0, 0, '0, '0, '0, '0);
    add_row(8'h5A,   1, 1, CLS_TOKEN, K_EOF,   '0,            '0);
    add_row(CH_APOS, 0, 0, '0, '0, '0, '0);
    add_row(CH_BSL,  0, 0, '0, '0, '0, '0);
    add_row("z",     1, 1, CLS_ERROR, '0,      ERR_BAD_ESC,   '0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].b, dir_rows[i].e);
      if (dir_rows[i].chk) begin
        if (run_res.size() == 0 || run_res[0].cls != dir_rows[i].cls ||
            run_res[0].kind != dir_rows[i].kind || run_res[0].err != dir_rows[i].err ||
            run_res[0].val != dir_rows[i].val) begin
          $error("directed row %0d: predicted result does not match table", i);
          failures++;
        end
      end
    end

    // Random part: fragments of source text, closed now and then by an end
    // marker so that open states meet the flush.
    while (src_text.size() < 250) add_fragment();
    add_byte("x", 1);
    foreach (src_text[i]) send_item(src_text[i].b, src_text[i].e);
    text_if.valid <= 1'b0;

    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Covered %0d input items (%0d end markers) across all lexer modes,",
             n_items, n_ends);
    $display("checked %0d tokens, %0d text bytes, %0d error reports.",
             n_tokens, n_texts, n_errors);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
